// File: hw/rtl/hsf_pkg.sv
package hsf_pkg;

   // Fixed field widths of the ports
   localparam int PIXEL_W = 8;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int RESULT_W = 13;

   // Size limit and register reset values
   localparam int DEFAULT_MAX_DIM = 4096;
   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_WIDTH = 13'd640;
   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_HEIGHT = 13'd480;

   // Only full-scale pixels count as white
   localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 8'd255;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

endpackage

// File: hw/rtl/horizontal_separator_finder.sv
// Horizontal separator finder.
// Pixels enter on the req_ channel in raster order, one item per pixel, and a
// pixel of 255 counts as white. Rows whose white share exceeds three quarters
// form the band; after the last pixel of each frame one item leaves on the
// rsp_ channel with the found flag, band center row (-1 if none) and band
// thickness (0 if none). The csr_ channel writes image_width (index 0) and
// image_height (index 1); write it only while no pixel item is in flight. A
// size written mid-frame takes effect at once for the pixels that follow.
// Size values of 0 act as 1 and values above MAX_DIM act as MAX_DIM.
// Throughput: one pixel per cycle, except that a frame's last pixel waits while
// the band register is full and not being taken. After that last pixel is
// accepted, the result item passes the input, band and result registers in turn.
// Reset restores 640 x 480 and starts a new frame at row 0, column 0.
// When rsp_ready stays low, one further finished frame is held in the band
// register; req_ready then drops only at the pixel that ends the next frame.
module horizontal_separator_finder import hsf_pkg::*; #(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PIXEL_W-1:0]         req_pixel,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic signed [RESULT_W-1:0] rsp_center_row,
   output logic [RESULT_W-1:0]        rsp_thickness
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = $clog2(MAX_DIM);

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0]      eff_width;
   logic [DIM_W-1:0]      eff_height;

   logic             band_valid;
   logic             band_ready;
   logic [CNT_W-1:0] band_top;
   logic [CNT_W-1:0] band_bottom;
   logic             band_seen;
   logic [DIM_W-1:0] band_height;

   // Configuration registers; unknown indexes are ignored
   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamp sizes into 1 .. MAX_DIM
   always_comb begin
      if (width_ff == '0) begin
         eff_width = DIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_DIM)) begin
         eff_width = DIM_W'(MAX_DIM);
      end else begin
         eff_width = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height = DIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_DIM)) begin
         eff_height = DIM_W'(MAX_DIM);
      end else begin
         eff_height = DIM_W'(height_ff);
      end
   end

   hsf_scan #(
      .MAX_DIM(MAX_DIM)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .eff_width   (eff_width),
      .eff_height  (eff_height),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel   (req_pixel),
      .band_valid  (band_valid),
      .band_ready  (band_ready),
      .band_top    (band_top),
      .band_bottom (band_bottom),
      .band_seen   (band_seen),
      .band_height (band_height)
   );

   hsf_result #(
      .MAX_DIM(MAX_DIM)
   ) u_result (
      .clock          (clock),
      .reset          (reset),
      .band_valid     (band_valid),
      .band_ready     (band_ready),
      .band_top       (band_top),
      .band_bottom    (band_bottom),
      .band_seen      (band_seen),
      .band_height    (band_height),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_center_row (rsp_center_row),
      .rsp_thickness  (rsp_thickness)
   );

endmodule

// File: hw/rtl/hsf_scan.sv
module hsf_scan import hsf_pkg::*; #(
   parameter int MAX_DIM = DEFAULT_MAX_DIM,
   localparam int DIM_W = $clog2(MAX_DIM + 1),
   localparam int CNT_W = $clog2(MAX_DIM)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [DIM_W-1:0]   eff_width,
   input  logic [DIM_W-1:0]   eff_height,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PIXEL_W-1:0] req_pixel,
   output logic               band_valid,
   input  logic               band_ready,
   output logic [CNT_W-1:0]   band_top,
   output logic [CNT_W-1:0]   band_bottom,
   output logic               band_seen,
   output logic [DIM_W-1:0]   band_height
);

   localparam int WIDE_W = DIM_W + 2;

   // Input register
   logic               pix_valid_ff, pix_valid_in;
   logic [PIXEL_W-1:0] pix_ff, pix_in;

   // Frame scan state
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] white_ff, white_in;
   logic [CNT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] bot_ff, bot_in;
   logic             top_seen_ff, top_seen_in;
   logic             bot_seen_ff, bot_seen_in;

   // Band register toward the result stage
   logic             band_valid_ff, band_valid_in;
   logic [CNT_W-1:0] band_top_ff, band_top_in;
   logic [CNT_W-1:0] band_bot_ff, band_bot_in;
   logic             band_seen_ff, band_seen_in;
   logic [DIM_W-1:0] band_height_ff, band_height_in;

   logic [DIM_W-1:0]  white_next;
   logic              row_end;
   logic              frame_end;
   logic              row_white;
   logic [WIDE_W-1:0] white_x4;
   logic [WIDE_W-1:0] width_x3;
   logic              step;
   logic [CNT_W-1:0]  top_upd, bot_upd;
   logic              top_seen_upd, bot_seen_upd;

   // Row and frame boundary detection
   always_comb begin
      white_next = white_ff + DIM_W'(pix_ff == WHITE_PIXEL);
      row_end = !((DIM_W'(col_ff) + DIM_W'(1)) < eff_width);
      frame_end = row_end && !((DIM_W'(row_ff) + DIM_W'(1)) < eff_height);
      white_x4 = {white_next, 2'b00};
      width_x3 = {1'b0, eff_width, 1'b0} + {2'b00, eff_width};
      row_white = white_x4 > width_x3;
   end

   // Track band limits at each row end
   always_comb begin
      top_upd = top_ff;
      bot_upd = bot_ff;
      top_seen_upd = top_seen_ff;
      bot_seen_upd = bot_seen_ff;
      if (row_white && !top_seen_ff) begin
         top_upd = row_ff;
         top_seen_upd = 1'b1;
      end
      if (!row_white && top_seen_ff && !bot_seen_ff) begin
         bot_upd = row_ff - CNT_W'(1);
         bot_seen_upd = 1'b1;
      end
      // Band still open at frame end closes on the last row
      if (frame_end && top_seen_upd && !bot_seen_upd) begin
         bot_upd = row_ff;
         bot_seen_upd = 1'b1;
      end
   end

   // Advance the pixel unless a frame end would overrun the band register
   assign step = pix_valid_ff && (!frame_end || !band_valid_ff || band_ready);
   assign req_ready = !pix_valid_ff || step;

   always_comb begin
      pix_valid_in = pix_valid_ff;
      pix_in = pix_ff;
      col_in = col_ff;
      row_in = row_ff;
      white_in = white_ff;
      top_in = top_ff;
      bot_in = bot_ff;
      top_seen_in = top_seen_ff;
      bot_seen_in = bot_seen_ff;
      band_valid_in = band_valid_ff;
      band_top_in = band_top_ff;
      band_bot_in = band_bot_ff;
      band_seen_in = band_seen_ff;
      band_height_in = band_height_ff;

      // Drop the band item once taken
      if (band_ready) begin
         band_valid_in = 1'b0;
      end

      if (step) begin
         pix_valid_in = 1'b0;
         if (!row_end) begin
            col_in = col_ff + CNT_W'(1);
            white_in = white_next;
         end else if (!frame_end) begin
            col_in = '0;
            white_in = '0;
            row_in = row_ff + CNT_W'(1);
            top_in = top_upd;
            bot_in = bot_upd;
            top_seen_in = top_seen_upd;
            bot_seen_in = bot_seen_upd;
         end else begin
            // Hand off the band and clear frame state
            band_valid_in = 1'b1;
            band_top_in = top_upd;
            band_bot_in = bot_upd;
            band_seen_in = top_seen_upd;
            band_height_in = eff_height;
            col_in = '0;
            row_in = '0;
            white_in = '0;
            top_in = '0;
            bot_in = '0;
            top_seen_in = 1'b0;
            bot_seen_in = 1'b0;
         end
      end

      // Hold a new pixel item
      if (req_valid && req_ready) begin
         pix_valid_in = 1'b1;
         pix_in = req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         white_ff <= '0;
         top_ff <= '0;
         bot_ff <= '0;
         top_seen_ff <= 1'b0;
         bot_seen_ff <= 1'b0;
         band_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         col_ff <= col_in;
         row_ff <= row_in;
         white_ff <= white_in;
         top_ff <= top_in;
         bot_ff <= bot_in;
         top_seen_ff <= top_seen_in;
         bot_seen_ff <= bot_seen_in;
         band_valid_ff <= band_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      band_top_ff <= band_top_in;
      band_bot_ff <= band_bot_in;
      band_seen_ff <= band_seen_in;
      band_height_ff <= band_height_in;
   end

   assign band_valid = band_valid_ff;
   assign band_top = band_top_ff;
   assign band_bottom = band_bot_ff;
   assign band_seen = band_seen_ff;
   assign band_height = band_height_ff;

`ifndef SYNTHESIS
   a_bottom_needs_top: assert property (@(posedge clock) disable iff (reset)
      !top_seen_ff |-> !bot_seen_ff)
      else $error("band bottom recorded without a top");

   a_bottom_below_top: assert property (@(posedge clock) disable iff (reset)
      bot_seen_ff |-> (bot_ff >= top_ff))
      else $error("band bottom above band top");

   a_band_ordered: assert property (@(posedge clock) disable iff (reset)
      (band_valid_ff && band_seen_ff) |-> (band_bot_ff >= band_top_ff))
      else $error("handed-off band is inverted");
`endif

endmodule

// File: hw/rtl/hsf_result.sv
module hsf_result import hsf_pkg::*; #(
   parameter int MAX_DIM = DEFAULT_MAX_DIM,
   localparam int DIM_W = $clog2(MAX_DIM + 1),
   localparam int CNT_W = $clog2(MAX_DIM)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       band_valid,
   output logic                       band_ready,
   input  logic [CNT_W-1:0]           band_top,
   input  logic [CNT_W-1:0]           band_bottom,
   input  logic                       band_seen,
   input  logic [DIM_W-1:0]           band_height,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic signed [RESULT_W-1:0] rsp_center_row,
   output logic [RESULT_W-1:0]        rsp_thickness
);

   localparam int EXT_W = DIM_W + 4;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       found_ff, found_in;
   logic signed [RESULT_W-1:0] center_ff, center_in;
   logic [RESULT_W-1:0]        thick_ff, thick_in;

   logic [DIM_W-1:0] thick;
   logic [DIM_W-1:0] center;
   logic [EXT_W-1:0] thick_x5;
   logic [EXT_W-1:0] center_x10;
   logic [EXT_W-1:0] height_x1;
   logic [EXT_W-1:0] height_x3;
   logic [EXT_W-1:0] height_x7;
   logic             ok;

   // Thickness, center and window checks
   always_comb begin
      thick = DIM_W'(band_bottom) - DIM_W'(band_top) + DIM_W'(1);
      center = DIM_W'(band_top) + (thick >> 1);
      thick_x5 = EXT_W'(thick) * EXT_W'(5);
      center_x10 = EXT_W'(center) * EXT_W'(10);
      height_x1 = EXT_W'(band_height);
      height_x3 = EXT_W'(band_height) * EXT_W'(3);
      height_x7 = EXT_W'(band_height) * EXT_W'(7);
      ok = !(thick_x5 > height_x1) && !(center_x10 < height_x3) &&
           !(center_x10 > height_x7);
   end

   assign band_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in = found_ff;
      center_in = center_ff;
      thick_in = thick_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // Load the result register with the finished band
      if (band_valid && band_ready) begin
         rsp_valid_in = 1'b1;
         if (band_seen) begin
            found_in = ok;
            center_in = RESULT_W'(center);
            thick_in = RESULT_W'(thick);
         end else begin
            found_in = 1'b0;
            center_in = '1;
            thick_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      center_ff <= center_in;
      thick_ff <= thick_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = found_ff;
   assign rsp_center_row = center_ff;
   assign rsp_thickness = thick_ff;

`ifndef SYNTHESIS
   a_load_gives_result: assert property (@(posedge clock) disable iff (reset)
      (band_valid && band_ready) |=> rsp_valid_ff)
      else $error("band taken but no result presented");

   a_found_has_band: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (thick_ff != '0))
      else $error("found flag without a band");

   a_no_band_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (center_ff == '1)) |-> ((thick_ff == '0) && !found_ff))
      else $error("missing band reported with nonzero thickness");
`endif

endmodule

// File: sim/horizontal_separator_finder_tb.sv
`timescale 1ns / 100ps

module horizontal_separator_finder_tb;
   import hsf_pkg::*;

   localparam int MAX_SIDE = DEFAULT_MAX_DIM;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_PIXELS = 180;
   localparam int PHASE_FRAMES = 3;
   localparam int SEND_IDLE_PCT [4] = '{0, 54, 0, 28};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 54, 28};

   // Unused register indexes; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic                       found;
      logic signed [RESULT_W-1:0] center_row;
      logic [RESULT_W-1:0]        thickness;
   } band_result_type;

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      bit                 hold_for_results;
   } pixel_item_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]      csr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [PIXEL_W-1:0]         req_pixel = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_found;
   logic signed [RESULT_W-1:0] rsp_center_row;
   logic [RESULT_W-1:0]        rsp_thickness;

   // Predicted band state and register copies
   logic [CSR_DATA_W-1:0] cfg_width;
   logic [CSR_DATA_W-1:0] cfg_height;
   int                    col_pos;
   int                    row_pos;
   int                    row_whites;
   int                    band_top;
   int                    band_bottom;
   bit                    top_found;
   bit                    bottom_found;

   pixel_item_type  pixel_queue [$];
   band_result_type band_results_due [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_req = 0;
   int hold_done = 0;
   int hold_left = 0;
   int errors = 0;
   int pixels_queued = 0;
   int pixels_sent = 0;
   int frames_checked = 0;
   int csr_writes = 0;

   horizontal_separator_finder u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_center_row (rsp_center_row),
      .rsp_thickness  (rsp_thickness)
   );

   always #5 clock = ~clock;

   // Clamp a size register to the range the block works with
   function automatic int eff_dim(input logic [CSR_DATA_W-1:0] v);
      if (v == 0) begin
         return 1;
      end
      if (v > MAX_SIDE) begin
         return MAX_SIDE;
      end
      return int'(v);
   endfunction

   function automatic void clear_band_state();
      col_pos = 0;
      row_pos = 0;
      row_whites = 0;
      band_top = 0;
      band_bottom = 0;
      top_found = 1'b0;
      bottom_found = 1'b0;
   endfunction

   // Advance the band scan by one pixel; return 1 when a frame closes
   function automatic bit band_step(input logic [PIXEL_W-1:0] pix,
                                    output band_result_type res);
      int  w;
      int  h;
      int  thick;
      int  center;
      bit  row_white;
      w = eff_dim(cfg_width);
      h = eff_dim(cfg_height);
      res.found = 1'b0;
      res.center_row = '1;
      res.thickness = '0;
      if (pix == WHITE_PIXEL) begin
         row_whites++;
      end
      if (col_pos + 1 < w) begin
         col_pos++;
         return 1'b0;
      end

      // Row end: open or close the band
      row_white = (row_whites * 4) > (w * 3);
      if (row_white && !top_found) begin
         band_top = row_pos;
         top_found = 1'b1;
      end
      if (!row_white && top_found && !bottom_found) begin
         band_bottom = row_pos - 1;
         bottom_found = 1'b1;
      end
      col_pos = 0;
      row_whites = 0;
      if (row_pos + 1 < h) begin
         row_pos++;
         return 1'b0;
      end

      // Frame end: a band still open runs to the last row
      if (top_found && !bottom_found) begin
         band_bottom = row_pos;
         bottom_found = 1'b1;
      end
      if (top_found) begin
         thick = band_bottom - band_top + 1;
         center = band_top + thick / 2;
         res.found = (thick * 5 <= h) && (center * 10 >= h * 3) && (center * 10 <= h * 7);
         res.center_row = RESULT_W'(center);
         res.thickness = RESULT_W'(thick);
      end
      clear_band_state();
      return 1'b1;
   endfunction

   // Driver: offer queued pixels, predict each accepted one
   always @(posedge clock) begin : pixel_driver
      band_result_type next_result;
      pixel_item_type  item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pixels_sent++;
            if (band_step(req_pixel, next_result)) begin
               band_results_due.insert(band_results_due.size(), next_result);
            end
         end
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() != 0 &&
                !(pixel_queue[0].hold_for_results && band_results_due.size() != 0) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               item = pixel_queue.pop_front();
               req_valid <= 1'b1;
               req_pixel <= item.pixel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result item against the oldest prediction
   always @(posedge clock) begin : result_monitor
      band_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (band_results_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result found=%0b center_row=%0d thickness=%0d",
                        $time, rsp_found, rsp_center_row, rsp_thickness);
            end else begin
               want = band_results_due.pop_front();
               frames_checked++;
               if (rsp_found !== want.found) begin
                  errors++;
                  $display("%0t: found expected %0b got %0b", $time, want.found, rsp_found);
               end
               if (rsp_center_row !== want.center_row) begin
                  errors++;
                  $display("%0t: center_row expected %0d got %0d",
                           $time, want.center_row, rsp_center_row);
               end
               if (rsp_thickness !== want.thickness) begin
                  errors++;
                  $display("%0t: thickness expected %0d got %0d",
                           $time, want.thickness, rsp_thickness);
               end
            end
         end
         // Hold off for a long stretch when asked, else stall at random
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_req != hold_done) begin
            hold_done++;
            hold_left = LONG_HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Write one register; keep valid high unless this is the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_IMAGE_WIDTH) begin
         cfg_width = val;
      end else if (idx == CSR_IMAGE_HEIGHT) begin
         cfg_height = val;
      end
      csr_writes++;
      if (last) begin
         csr_valid <= 1'b0;
      end
   endtask

   task automatic set_size(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      write_reg(CSR_IMAGE_WIDTH, w, 1'b0);
      write_reg(CSR_IMAGE_HEIGHT, h, 1'b1);
   endtask

   task automatic queue_pixel(input logic [PIXEL_W-1:0] p, input bit hold);
      pixel_item_type item;
      item.pixel = p;
      item.hold_for_results = hold;
      pixel_queue.insert(pixel_queue.size(), item);
      pixels_queued++;
   endtask

   // Wait until every pixel is taken and every result checked, then settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || band_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Queue one row with a chosen white share, often right at the threshold
   task automatic queue_row(input int w, input bit white_row, input bit hold_first);
      logic [PIXEL_W-1:0] row_buf [0:MAX_SIDE-1];
      logic [PIXEL_W-1:0] t;
      int                 lim;
      int                 nwhite;
      int                 j;
      lim = (3 * w) / 4;
      if (white_row) begin
         nwhite = ($urandom_range(0, 2) == 0) ? lim + 1 : $urandom_range(lim + 1, w);
      end else begin
         nwhite = ($urandom_range(0, 2) == 0) ? lim : $urandom_range(0, lim);
      end
      for (int i = 0; i < w; i++) begin
         if (i < nwhite) begin
            row_buf[i] = WHITE_PIXEL;
         end else begin
            row_buf[i] = $urandom_range(0, 1) ? 8'd0 : PIXEL_W'($urandom_range(0, 254));
         end
      end
      for (int i = w - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = row_buf[i];
         row_buf[i] = row_buf[j];
         row_buf[j] = t;
      end
      for (int i = 0; i < w; i++) begin
         queue_pixel(row_buf[i], hold_first && i == 0);
      end
   endtask

   // Queue one frame: usually one band, sometimes stray white rows below it
   task automatic queue_frame(input int w, input int h, input bit hold_first);
      int top;
      int thick;
      bit has_band;
      bit white;
      has_band = ($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 1)) begin
         top = $urandom_range(h * 3 / 10, h / 2);
         thick = $urandom_range(1, (h / 5 > 1) ? h / 5 : 1);
      end else begin
         top = $urandom_range(0, h - 1);
         thick = $urandom_range(1, h - top);
      end
      if (top > h - 1) begin
         top = h - 1;
      end
      if (thick > h - top) begin
         thick = h - top;
      end
      for (int r = 0; r < h; r++) begin
         white = has_band && ((r >= top && r < top + thick) ||
                              (r > top + thick && $urandom_range(0, 3) == 0));
         queue_row(w, white, hold_first && r == 0);
      end
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] w_reg;
      logic [CSR_DATA_W-1:0] h_reg;
      int                    start_pixels;
      int                    start_frames;

      cfg_width = RESET_IMAGE_WIDTH;
      cfg_height = RESET_IMAGE_HEIGHT;
      clear_band_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Spare indexes are ignored; zero sizes act as one: 1x1 frames
      write_reg(CSR_SPARE_2, 13'h1FFF, 1'b0);
      write_reg(CSR_SPARE_3, 13'h0005, 1'b0);
      set_size(13'd0, 13'd0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd254, 1'b0);
      wait_drained();

      // One-row band in the middle third, thin enough to be found
      set_size(13'd2, 13'd5);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd254, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd255, 1'b0);
      wait_drained();

      // Band running to the frame's last row
      set_size(13'd1, 13'd4);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd17, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd255, 1'b0);
      wait_drained();

      // Exactly three quarters white is not enough
      set_size(13'd4, 13'd1);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd0, 1'b0);
      wait_drained();

      // Oversized height, then shrink it mid-frame so row 3 ends the frame
      set_size(13'd1, 13'h1FFF);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd0, 1'b0);
      wait_drained();
      set_size(13'd1, 13'd4);
      queue_pixel(8'd255, 1'b0);
      wait_drained();

      // Back-pressure: stall results long while tiny frames keep coming
      set_size(13'd2, 13'd2);
      for (int f = 0; f < 12; f++) begin
         queue_frame(2, 2, f == 6);
      end
      hold_req <= hold_req + 1;
      wait_drained();

      // Random sizes and frames under each idling mix
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct <= SEND_IDLE_PCT[ph];
         recv_stall_pct <= RECV_STALL_PCT[ph];
         start_pixels = pixels_queued;
         start_frames = frames_checked;
         while (pixels_queued - start_pixels < PHASE_PIXELS ||
                frames_checked - start_frames < PHASE_FRAMES) begin
            w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            set_size(w_reg, h_reg);
            for (int f = 0; f < 3; f++) begin
               queue_frame(eff_dim(w_reg), eff_dim(h_reg), $urandom_range(0, 4) == 0);
            end
            wait_drained();
         end
      end

      errors += band_results_due.size();
      $display("Checked %0d frame results from %0d pixels after %0d register writes.",
               frames_checked, pixels_sent, csr_writes);
      $display("Sizes from 1x1 to 40 per side, a clamped height changed mid-frame, four idling mixes and a long stall.");
      if (errors == 0) begin
         $display("horizontal_separator_finder verification clean");
      end else begin
         $display("horizontal_separator_finder verification failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #10_000_000;
      $display("horizontal_separator_finder verification failed");
      $finish;
   end

endmodule

// File: horizontal_separator_finder.f
hw/rtl/hsf_pkg.sv
hw/rtl/hsf_scan.sv
hw/rtl/hsf_result.sv
hw/rtl/horizontal_separator_finder.sv
sim/horizontal_separator_finder_tb.sv
